// ===== rtl/mrr_pkg.sv =====
// mrr_pkg: shared types for the Miller-Rabin round core.
// No dependencies; used by controller, datapath and top level.
package mrr_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD,
        ST_SPLIT,
        ST_POW_CHK,
        ST_POW_MUL,
        ST_POW_SQ_GO,
        ST_POW_SQR,
        ST_SQ_CHK,
        ST_SQ_MUL,
        ST_SQ_EVAL,
        ST_FINAL,
        ST_OUT
    } mrr_state_t;

    typedef enum logic [1:0] {
        MUL_ACC_SQ,
        MUL_SQ_SQ,
        MUL_X_X
    } mrr_mulsel_t;

    typedef struct packed {
        logic        load;
        logic        mod_start;
        logic        split_step;
        logic        mul_start;
        mrr_mulsel_t mul_sel;
        logic        mul_commit;
        logic        exp_shift;
        logic        sq_eval;
        logic        set_verdict;
        logic        verdict_val;
        logic        x_init;
    } mrr_cmd_t;

    typedef struct packed {
        logic trivial;
        logic trivial_verdict;
        logic mod_busy;
        logic a_zero;
        logic d_odd;
        logic exp_zero;
        logic exp_lsb;
        logic mul_busy;
        logic t_zero;
        logic witness;
        logic x_is_one;
    } mrr_stat_t;

endpackage

// ===== rtl/miller_rabin_round_core.sv =====
// miller_rabin_round_core: top level of one Miller-Rabin round.
// Depends on mrr_pkg, mrr_ctrl and mrr_datapath.
//
// One item carries a candidate n and a base a; one verdict item comes back
// (0 = composite proven, 1 = probably prime for this base). Even and small
// candidates resolve without any arithmetic. For odd n the base is reduced
// mod n bit-serially, n-1 is split into d*2^t one bit a cycle, then a^d
// mod n runs by square-and-multiply and up to t squarings follow.
// Every modular multiply goes through one shared shift-add unit that steps
// through the multiplier one bit at a time until its remaining bits are zero.
// The core works on one item at a time; the verdict register holds until
// taken and a new item is accepted once it is gone.
module miller_rabin_round_core
#(
    parameter int NUM_WIDTH = 63
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [127:0]  s_tdata,  // [62:0] candidate, [125:63] base
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata   // [0] verdict
);

    mrr_pkg::mrr_cmd_t  cmd;
    mrr_pkg::mrr_stat_t stat;
    logic               idle, done, verdict;
    logic               start;

    assign s_tready = idle;
    assign start    = s_tvalid && idle;
    assign m_tvalid = done;
    assign m_tdata  = {7'd0, verdict};

    mrr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .out_taken (m_tready),
        .stat      (stat),
        .cmd       (cmd),
        .idle      (idle),
        .done      (done)
    );

    mrr_datapath #(.W(NUM_WIDTH)) u_dp
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .n_in    (s_tdata[NUM_WIDTH-1:0]),
        .a_in    (s_tdata[63 +: NUM_WIDTH]),
        .cmd     (cmd),
        .stat    (stat),
        .verdict (verdict)
    );

endmodule

// ===== rtl/mrr_ctrl.sv =====
// mrr_ctrl: sequencer for one Miller-Rabin round.
// Depends on mrr_pkg command/status types.
module mrr_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             out_taken,
    input  mrr_pkg::mrr_stat_t stat,
    output mrr_pkg::mrr_cmd_t  cmd,
    output logic             idle,
    output logic             done
);

    mrr_pkg::mrr_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= mrr_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.mul_sel = mrr_pkg::MUL_ACC_SQ;
        idle = 1'b0;
        done = 1'b0;
        case (state_reg)
            mrr_pkg::ST_IDLE:
            begin
                idle = 1'b1;
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = mrr_pkg::ST_MOD;
                end
            end
            mrr_pkg::ST_MOD:
            begin
                // trivial candidates resolve right away
                if (stat.trivial)
                begin
                    cmd.set_verdict = 1'b1;
                    cmd.verdict_val = stat.trivial_verdict;
                    state_next = mrr_pkg::ST_OUT;
                end
                else
                begin
                    cmd.mod_start = 1'b1;
                    state_next = mrr_pkg::ST_SPLIT;
                end
            end
            mrr_pkg::ST_SPLIT:
            begin
                if (!stat.mod_busy)
                begin
                    if (stat.a_zero)
                    begin
                        cmd.set_verdict = 1'b1;
                        cmd.verdict_val = 1'b1;
                        state_next = mrr_pkg::ST_OUT;
                    end
                    else if (stat.d_odd)
                        state_next = mrr_pkg::ST_POW_CHK;
                    else
                        cmd.split_step = 1'b1;
                end
            end
            mrr_pkg::ST_POW_CHK:
            begin
                if (stat.exp_zero)
                begin
                    // x starts at a^d
                    cmd.x_init = 1'b1;
                    state_next = mrr_pkg::ST_SQ_CHK;
                end
                else if (stat.exp_lsb)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel = mrr_pkg::MUL_ACC_SQ;
                    state_next = mrr_pkg::ST_POW_MUL;
                end
                else
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel = mrr_pkg::MUL_SQ_SQ;
                    state_next = mrr_pkg::ST_POW_SQR;
                end
            end
            mrr_pkg::ST_POW_MUL:
            begin
                cmd.mul_sel = mrr_pkg::MUL_ACC_SQ;
                if (!stat.mul_busy)
                begin
                    cmd.mul_commit = 1'b1;
                    state_next = mrr_pkg::ST_POW_SQ_GO;
                end
            end
            mrr_pkg::ST_POW_SQ_GO:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel = mrr_pkg::MUL_SQ_SQ;
                state_next = mrr_pkg::ST_POW_SQR;
            end
            mrr_pkg::ST_POW_SQR:
            begin
                cmd.mul_sel = mrr_pkg::MUL_SQ_SQ;
                if (!stat.mul_busy)
                begin
                    cmd.mul_commit = 1'b1;
                    cmd.exp_shift = 1'b1;
                    state_next = mrr_pkg::ST_POW_CHK;
                end
            end
            mrr_pkg::ST_SQ_CHK:
            begin
                if (stat.t_zero)
                    state_next = mrr_pkg::ST_FINAL;
                else
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel = mrr_pkg::MUL_X_X;
                    state_next = mrr_pkg::ST_SQ_MUL;
                end
            end
            mrr_pkg::ST_SQ_MUL:
            begin
                cmd.mul_sel = mrr_pkg::MUL_X_X;
                if (!stat.mul_busy)
                begin
                    cmd.mul_commit = 1'b1;
                    state_next = mrr_pkg::ST_SQ_EVAL;
                end
            end
            mrr_pkg::ST_SQ_EVAL:
            begin
                if (stat.witness)
                begin
                    cmd.set_verdict = 1'b1;
                    cmd.verdict_val = 1'b0;
                    state_next = mrr_pkg::ST_OUT;
                end
                else
                begin
                    cmd.sq_eval = 1'b1;
                    state_next = mrr_pkg::ST_SQ_CHK;
                end
            end
            mrr_pkg::ST_FINAL:
            begin
                cmd.set_verdict = 1'b1;
                cmd.verdict_val = stat.x_is_one;
                state_next = mrr_pkg::ST_OUT;
            end
            mrr_pkg::ST_OUT:
            begin
                done = 1'b1;
                if (out_taken)
                    state_next = mrr_pkg::ST_IDLE;
            end
            default:
                state_next = mrr_pkg::ST_IDLE;
        endcase
    end

    // a result is only ever presented after a run was loaded
    ast_done_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done) |-> !$past(idle))
        else $error("result raised straight from idle");
    // one item per run: no load while busy
    ast_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> idle)
        else $error("load outside idle");
    ast_mul_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_commit |-> !stat.mul_busy)
        else $error("multiply result taken while busy");

endmodule

// ===== rtl/mrr_datapath.sv =====
// mrr_datapath: operand registers, bit-serial modular reduce and multiply.
// Depends on mrr_pkg command/status types.
module mrr_datapath
#(
    parameter int W = 63
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [W-1:0]       n_in,
    input  logic [W-1:0]       a_in,
    input  mrr_pkg::mrr_cmd_t  cmd,
    output mrr_pkg::mrr_stat_t stat,
    output logic               verdict
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  n_reg, nm1_reg, a_reg;
    logic [W-1:0]  acc_reg, sq_reg, x_reg, prev_reg, d_reg;
    logic [CW-1:0] t_reg;
    logic          verdict_reg;

    // shared modular unit: reduce (a mod n) or shift-add multiply
    logic          mod_busy_reg, mul_busy_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  r_reg, racc_reg, radd_reg, ry_reg;

    logic [W:0]    r_shift, r_sub, s_sum, s_sub, ad_sh, ad_sub;
    logic [W-1:0]  r_new, s_new, ad_new, op_x, op_y, mul_res;

    always_comb
    begin
        case (cmd.mul_sel)
            mrr_pkg::MUL_ACC_SQ: begin op_x = acc_reg; op_y = sq_reg; end
            mrr_pkg::MUL_SQ_SQ:  begin op_x = sq_reg;  op_y = sq_reg; end
            default:             begin op_x = x_reg;   op_y = x_reg;  end
        endcase
        // restoring remainder, one bit of a per cycle, MSB first
        r_shift = {r_reg, a_reg[cnt_reg]};
        r_sub   = r_shift - {1'b0, n_reg};
        r_new   = r_sub[W] ? r_shift[W-1:0] : r_sub[W-1:0];
        s_sum   = {1'b0, racc_reg} + {1'b0, radd_reg};
        s_sub   = s_sum - {1'b0, n_reg};
        s_new   = ry_reg[0] ? (s_sub[W] ? s_sum[W-1:0] : s_sub[W-1:0]) : racc_reg;
        ad_sh   = {radd_reg, 1'b0};
        ad_sub  = ad_sh - {1'b0, n_reg};
        ad_new  = ad_sub[W] ? ad_sh[W-1:0] : ad_sub[W-1:0];
        mul_res = racc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_busy_reg <= 1'b0;
            mul_busy_reg <= 1'b0;
            verdict_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.mod_start)
                mod_busy_reg <= 1'b1;
            else if (mod_busy_reg && cnt_reg == '0)
                mod_busy_reg <= 1'b0;
            if (cmd.mul_start)
                mul_busy_reg <= 1'b1;
            else if (mul_busy_reg && ry_reg == '0)
                mul_busy_reg <= 1'b0;
            if (cmd.set_verdict)
                verdict_reg <= cmd.verdict_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg   <= n_in;
            a_reg   <= a_in;
            nm1_reg <= n_in - W'(1);
            d_reg   <= n_in - W'(1);
            t_reg   <= '0;
            acc_reg <= W'(1);
        end
        if (cmd.mod_start)
        begin
            r_reg   <= '0;
            cnt_reg <= CW'(W - 1);
        end
        else if (mod_busy_reg)
        begin
            r_reg <= r_new;
            if (cnt_reg == '0)
                sq_reg <= r_new;
            else
                cnt_reg <= cnt_reg - CW'(1);
        end
        if (cmd.split_step)
        begin
            d_reg <= d_reg >> 1;
            t_reg <= t_reg + CW'(1);
        end
        if (cmd.mul_start)
        begin
            racc_reg <= '0;
            radd_reg <= op_x;
            ry_reg   <= op_y;
        end
        else if (mul_busy_reg && ry_reg != '0)
        begin
            racc_reg <= s_new;
            radd_reg <= ad_new;
            ry_reg   <= ry_reg >> 1;
        end
        if (cmd.mul_commit)
        begin
            case (cmd.mul_sel)
                mrr_pkg::MUL_ACC_SQ: acc_reg <= mul_res;
                mrr_pkg::MUL_SQ_SQ:  sq_reg  <= mul_res;
                default:
                begin
                    prev_reg <= x_reg;
                    x_reg    <= mul_res;
                end
            endcase
        end
        if (cmd.exp_shift)
            d_reg <= d_reg >> 1;
        // entering squaring phase: x starts at a^d
        if (cmd.x_init)
            x_reg <= acc_reg;
        if (cmd.sq_eval)
            t_reg <= t_reg - CW'(1);
    end

    always_comb
    begin
        stat.trivial         = (n_reg < W'(3)) || !n_reg[0];
        stat.trivial_verdict = (n_reg == W'(2));
        stat.mod_busy        = mod_busy_reg;
        stat.a_zero          = (sq_reg == '0);
        stat.d_odd           = d_reg[0];
        stat.exp_zero        = (d_reg == '0);
        stat.exp_lsb         = d_reg[0];
        stat.mul_busy        = mul_busy_reg;
        stat.t_zero          = (t_reg == '0);
        stat.witness         = (x_reg == W'(1)) && (prev_reg != W'(1))
                               && (prev_reg != nm1_reg);
        stat.x_is_one        = (x_reg == W'(1));
    end

    assign verdict = verdict_reg;

endmodule
